// File: src/pfba_pkg.sv
package pfba_pkg;

	localparam int MAX_PAGES_DEF = 16;
	localparam int MAX_BPP_DEF   = 64;

	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 2;
	localparam int BPP_W    = 7;
	localparam int LIMIT_W  = 5;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [BPP_W-1:0]   BPP_RESET   = BPP_W'(64);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic                req_type;
		logic [HANDLE_W-1:0] block_handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] result_handle;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic dec;
		logic init_step;
		logic act;
		logic link_rd;
		logic pop;
		logic push;
		logic fail;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_free;
		logic found;
		logic can_act;
		logic free_ok;
		logic init_last;
	} stat_t;

endpackage

// File: src/pfba_ctrl.sv
module pfba_ctrl import pfba_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output cmd_t  cmd,
	input  stat_t stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_INIT = 3'd2;
	localparam logic [2:0] S_ACT  = 3'd3;
	localparam logic [2:0] S_LRD  = 3'd4;
	localparam logic [2:0] S_POP  = 3'd5;
	localparam logic [2:0] S_PUSH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       finish;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				if (stat.is_free) begin
					if (stat.free_ok) begin
						state_d = S_PUSH;
					end else if (out_free) begin
						cmd.fail = 1'b1;
						finish   = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					if (stat.found) begin
						state_d = S_LRD;
					end else if (stat.can_act) begin
						state_d = S_INIT;
					end else if (out_free) begin
						cmd.fail = 1'b1;
						finish   = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				if (out_free) begin
					cmd.act = 1'b1;
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_LRD: begin
				cmd.link_rd = 1'b1;
				state_d     = S_POP;
			end
			S_POP: begin
				if (out_free) begin
					cmd.pop = 1'b1;
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PUSH: begin
				if (out_free) begin
					cmd.push = 1'b1;
					finish   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/pfba_dp.sv
module pfba_dp import pfba_pkg::*; #(
	parameter int MAX_PAGES           = MAX_PAGES_DEF,
	parameter int MAX_BLOCKS_PER_PAGE = MAX_BPP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  req_t                 req_data,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output rsp_t                 rsp_data
);

	localparam int PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int BW    = $clog2(MAX_BLOCKS_PER_PAGE);
	localparam int NW    = $clog2(MAX_BLOCKS_PER_PAGE + 1);
	localparam int CNTW  = $clog2(MAX_PAGES + 1);
	localparam int SLOTS = MAX_PAGES * MAX_BLOCKS_PER_PAGE;
	localparam int SW    = $clog2(SLOTS);
	localparam int BCW   = (NW > BPP_W) ? NW : BPP_W;
	localparam int LCW   = (CNTW > LIMIT_W) ? CNTW : LIMIT_W;
	localparam int IW    = (NW > HANDLE_W) ? NW : HANDLE_W;
	// Handle split by multiplying with a scaled reciprocal; exact for every 10-bit handle.
	localparam int RecipK = HANDLE_W + $clog2(MAX_BLOCKS_PER_PAGE);
	localparam int RecipM = ((1 << RecipK) + MAX_BLOCKS_PER_PAGE - 1) / MAX_BLOCKS_PER_PAGE;
	localparam int PW     = HANDLE_W + RecipK + 1;

	function automatic logic [SW-1:0] slot_of(input logic [PGW-1:0] pg,
		input logic [BW-1:0] idx);
		logic [SW:0] s;
		s = (SW+1)'(pg) * (SW+1)'(MAX_BLOCKS_PER_PAGE) + (SW+1)'(idx);
		return s[SW-1:0];
	endfunction

	logic [BPP_W-1:0]   bpp_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNTW-1:0]    count_q;
	logic [MAX_PAGES-1:0] nonempty_q;

	req_t               req_q;
	logic [PW-1:0]      prod_q;
	logic [PGW-1:0]     pg_q;
	logic [BW-1:0]      idx_q;
	logic [NW-1:0]      n_q;
	logic [BW-1:0]      i_q;
	logic [BW-1:0]      head_rd_q;
	logic [BW:0]        link_rd_q;
	logic [SW-1:0]      slot_q;
	rsp_t               out_q;

	logic [BW-1:0]      head_mem [MAX_PAGES];
	logic [BW:0]        link_mem [SLOTS];

	logic [NW-1:0]       eff_bpp;
	logic [CNTW-1:0]     eff_limit;
	logic [HANDLE_W-1:0] q_w;
	logic [HANDLE_W-1:0] r_w;
	logic                found;
	logic [PGW-1:0]      prio_pg;
	logic [PGW-1:0]      dec_pg;
	logic                init_last;
	logic [SW-1:0]       link_raddr;
	logic [SW-1:0]       link_waddr;
	logic [BW:0]         link_wdata;
	logic                link_we;

	always_comb begin
		if (bpp_q == '0) begin
			eff_bpp = NW'(1);
		end else if (BCW'(bpp_q) > BCW'(MAX_BLOCKS_PER_PAGE)) begin
			eff_bpp = NW'(MAX_BLOCKS_PER_PAGE);
		end else begin
			eff_bpp = NW'(bpp_q);
		end
	end

	always_comb begin
		if (limit_q == '0) begin
			eff_limit = CNTW'(1);
		end else if (LCW'(limit_q) > LCW'(MAX_PAGES)) begin
			eff_limit = CNTW'(MAX_PAGES);
		end else begin
			eff_limit = CNTW'(limit_q);
		end
	end

	assign q_w = HANDLE_W'(prod_q >> RecipK);
	assign r_w = req_q.block_handle - q_w * HANDLE_W'(MAX_BLOCKS_PER_PAGE);

	// Lowest page that still has a free block; only active pages ever set their bit.
	always_comb begin
		found   = 1'b0;
		prio_pg = '0;
		for (int p = MAX_PAGES - 1; p >= 0; p--) begin
			if (nonempty_q[p]) begin
				found   = 1'b1;
				prio_pg = PGW'(p);
			end
		end
	end

	always_comb begin
		if (req_q.req_type == REQ_FREE) begin
			dec_pg = PGW'(q_w);
		end else if (found) begin
			dec_pg = prio_pg;
		end else begin
			dec_pg = PGW'(count_q);
		end
	end

	assign init_last = ((NW'(i_q) + NW'(1)) == n_q);

	assign stat.is_free   = (req_q.req_type == REQ_FREE);
	assign stat.found     = found;
	assign stat.can_act   = (count_q < eff_limit);
	assign stat.free_ok   = (q_w < HANDLE_W'(count_q)) && (IW'(r_w) < IW'(eff_bpp));
	assign stat.init_last = init_last;

	assign link_raddr = slot_of(pg_q, head_rd_q);
	assign link_we    = cmd.push || cmd.init_step;
	assign link_waddr = cmd.push ? slot_of(pg_q, idx_q) : slot_of(pg_q, i_q);
	assign link_wdata = cmd.push ? {!nonempty_q[pg_q], head_rd_q} : {init_last, i_q + BW'(1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q      <= BPP_RESET;
			limit_q    <= LIMIT_RESET;
			count_q    <= '0;
			nonempty_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BPP:   bpp_q   <= cfg_wdata[BPP_W-1:0];
					CFG_LIMIT: limit_q <= cfg_wdata[LIMIT_W-1:0];
				endcase
			end
			if (cmd.act) begin
				nonempty_q[pg_q] <= (n_q > NW'(1));
				count_q          <= count_q + CNTW'(1);
			end else if (cmd.pop) begin
				nonempty_q[pg_q] <= !link_rd_q[BW];
			end else if (cmd.push) begin
				nonempty_q[pg_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_data;
			prod_q <= PW'(req_data.block_handle) * PW'(RecipM);
		end
		if (cmd.dec) begin
			pg_q  <= dec_pg;
			idx_q <= BW'(r_w);
			n_q   <= eff_bpp;
			i_q   <= '0;
		end else if (cmd.init_step) begin
			i_q <= i_q + BW'(1);
		end
		if (cmd.link_rd) begin
			slot_q <= link_raddr;
		end
		if (cmd.act) begin
			out_q <= {HANDLE_W'(slot_of(pg_q, '0)), ST_OK};
		end else if (cmd.pop) begin
			out_q <= {HANDLE_W'(slot_q), ST_OK};
		end else if (cmd.push) begin
			out_q <= {req_q.block_handle, ST_OK};
		end else if (cmd.fail) begin
			out_q <= {HANDLE_W'(0), (req_q.req_type == REQ_FREE) ? ST_INVALID : ST_OOM};
		end
	end

	// Page head memory: one read port used while decoding, one write port.
	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			head_rd_q <= head_mem[dec_pg];
		end
		if (cmd.act) begin
			head_mem[pg_q] <= BW'(1);
		end else if (cmd.pop) begin
			head_mem[pg_q] <= link_rd_q[BW-1:0];
		end else if (cmd.push) begin
			head_mem[pg_q] <= idx_q;
		end
	end

	// Link memory: each entry holds a null flag above the next block index.
	always_ff @(posedge clk) begin
		if (cmd.link_rd) begin
			link_rd_q <= link_mem[link_raddr];
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
	end

	assign rsp_data = out_q;

endmodule

// File: src/paged_fixed_block_allocator.sv
// Allocate when an active page has a free block: decode, read the link entry, then register the result.
// Allocate that opens a new page: one link entry written per cycle, then the result is registered.
// Free: decode, then push the block and register the result; an error result is registered at decode.
// A new request is taken the cycle after a result is registered, so only one request is in work at a time.
// arst_n clears the page state and loads blocks_per_page = 64 and page_limit = 16.
module paged_fixed_block_allocator import pfba_pkg::*; #(
	parameter int MAX_PAGES           = MAX_PAGES_DEF,
	parameter int MAX_BLOCKS_PER_PAGE = MAX_BPP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp_data
);

	cmd_t  cmd;
	stat_t stat;

	pfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pfba_dp #(
		.MAX_PAGES           (MAX_PAGES),
		.MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_data  (req_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_data  (rsp_data)
	);

endmodule

// File: src/pfba_chk.sv
module pfba_chk import pfba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// Status codes above the invalid-handle code are never produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_OOM ||
			rsp_data.status == ST_INVALID))
		else $error("reserved status code on result beat");

	// Every error result carries a zero handle.
	a_error_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.result_handle == '0))
		else $error("error result with nonzero handle");

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while the previous one is still in work");

	// A stalled result beat holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("result beat dropped or changed while stalled");

endmodule

bind paged_fixed_block_allocator pfba_chk u_chk (.*);
